### hdl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants for the lru key/value cache
// request beat layout, lookup result and fixed codes used by all files
// ----------------------------------------------------------------------------
package lkvc_pkg;

  typedef enum logic [0:0] {
    REQ_GET = 1'b0,
    REQ_SET = 1'b1
  } req_kind_t;

  typedef struct packed {
    req_kind_t          kind;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] value;
  } lookup_t;

  localparam logic [4:0]         CAPACITY_RESET = 5'd5;
  localparam logic signed [31:0] MISS_VALUE     = -32'sd1;

endpackage

### hdl/lkvc_slots.sv
// ----------------------------------------------------------------------------
// lkvc_slots: slot array of the lru key/value cache
// parallel key compare, recency ranks and registered set update
// ----------------------------------------------------------------------------
module lkvc_slots
  import lkvc_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [4:0] capacity,
  input  logic       upd_en,
  input  req_t       req,
  output lookup_t    lookup
);

  localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CAPW = ($clog2(ENTRIES + 1) > 5) ? $clog2(ENTRIES + 1) : 5;
  localparam logic [CAPW-1:0] ENTRIES_C = CAPW'(ENTRIES);

  logic [ENTRIES-1:0]        valid_r, valid_nxt;
  logic [AW-1:0]             age_r   [ENTRIES];
  logic [AW-1:0]             age_nxt [ENTRIES];
  logic signed [31:0]        key_r   [ENTRIES];
  logic signed [31:0]        value_r [ENTRIES];

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] evict;
  logic [ENTRIES-1:0] survive;
  logic [ENTRIES-1:0] free_oh;
  logic [ENTRIES-1:0] wr_oh;
  logic               any_hit;
  logic [AW-1:0]      hit_age;
  logic signed [31:0] hit_value;
  logic [CAPW-1:0]    cap_ext;
  logic [CAPW-1:0]    eff_cap;
  logic [AW-1:0]      keep;

  // effective capacity: zero counts as one, saturate at the slot count
  always_comb begin
    cap_ext = CAPW'(capacity);
    if (cap_ext == '0) begin
      eff_cap = CAPW'(1);
    end else if (cap_ext > ENTRIES_C) begin
      eff_cap = ENTRIES_C;
    end else begin
      eff_cap = cap_ext;
    end
    keep = AW'(eff_cap - CAPW'(1));
  end

  // parallel compare, and-or read of the matching slot
  always_comb begin
    hit_age   = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (key_r[i] == req.key);
      evict[i] = valid_r[i] && (age_r[i] >= keep);
      if (match[i]) begin
        hit_age   = hit_age | age_r[i];
        hit_value = hit_value | value_r[i];
      end
    end
    any_hit = |match;
    survive = valid_r & ~evict;
    // lowest slot left free after eviction
    free_oh = ~survive & (survive + ENTRIES'(1));
  end

  assign lookup.hit   = any_hit;
  assign lookup.value = any_hit ? hit_value : MISS_VALUE;

  always_comb begin
    valid_nxt = valid_r;
    wr_oh     = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      age_nxt[i] = age_r[i];
    end
    if (any_hit) begin
      // update: promote the hit slot, shift younger ones down a rank
      wr_oh = match;
      for (int i = 0; i < ENTRIES; i++) begin
        if (match[i]) begin
          age_nxt[i] = '0;
        end else if (valid_r[i] && (age_r[i] < hit_age)) begin
          age_nxt[i] = age_r[i] + AW'(1);
        end
      end
    end else begin
      // insert: drop the oldest ranks, age survivors, fill the free slot
      wr_oh     = free_oh;
      valid_nxt = survive | free_oh;
      for (int i = 0; i < ENTRIES; i++) begin
        if (survive[i]) begin
          age_nxt[i] = age_r[i] + AW'(1);
        end else begin
          age_nxt[i] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_r[i] <= '0;
      end
    end else if (upd_en) begin
      valid_r <= valid_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        age_r[i] <= age_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (upd_en && wr_oh[i]) begin
        value_r[i] <= req.value;
        if (!any_hit) begin
          key_r[i] <= req.key;
        end
      end
    end
  end

endmodule

### hdl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key/value store, lru replacement
// gets return hit and value, sets update or insert with eviction
// ----------------------------------------------------------------------------
// usage
//   in_*  : request beats (in_req_type 0 = get, 1 = set, key, write value),
//           taken when in_valid is high and in_stall is low
//   out_* : one result beat per get (out_hit, out_read_value), sets give none
//   cfg_* : cfg_wr_en writes the 5-bit capacity; the user must do so only
//           while the block idles, which the block itself does not enforce
// path: a get goes request stage, then output register (two register stages)
// throughput: one request per cycle while in_stall is low; the compare and
//   rank update of a request land as it retires, so the next one sees them
// stall: a stalled result holds in the output register; the request stage
//   still takes one more beat, and in_stall rises only when a get waits in
//   that stage behind a held result
// reset: all slots empty, all ranks zero, capacity 5, both channels idle
// capacity zero acts as one, values above ENTRIES saturate at ENTRIES
// ----------------------------------------------------------------------------
module lru_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic signed [31:0] in_lookup_key,
  input  logic signed [31:0] in_write_value,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic signed [31:0] out_read_value,
  // capacity register
  input  logic               cfg_wr_en,
  input  logic [4:0]         cfg_wr_data
);

  logic [4:0]  capacity_r;
  logic        stage_v_r, stage_v_nxt;
  req_t        stage_r;
  logic        out_valid_r, out_valid_nxt;
  lookup_t     out_r;
  lookup_t     lookup;
  logic        accept_in;
  logic        stage_is_get;
  logic        out_free;
  logic        proc;

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RESET;
    end else if (cfg_wr_en) begin
      capacity_r <= cfg_wr_data;
    end
  end

  // request in the stage retires when it needs no result slot or one is free
  assign stage_is_get = (stage_r.kind == REQ_GET);
  assign out_free     = !out_valid_r || !out_stall;
  assign proc         = stage_v_r && (!stage_is_get || out_free);
  assign in_stall     = stage_v_r && !proc;
  assign accept_in    = in_valid && !in_stall;

  always_comb begin
    stage_v_nxt = stage_v_r;
    if (accept_in) begin
      stage_v_nxt = 1'b1;
    end else if (proc) begin
      stage_v_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (proc && stage_is_get) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      stage_v_r   <= stage_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request stage payload
  always_ff @(posedge clk) begin
    if (accept_in) begin
      stage_r.kind  <= req_kind_t'(in_req_type);
      stage_r.key   <= in_lookup_key;
      stage_r.value <= in_write_value;
    end
  end

  // slot array: compare and update for the staged request
  lkvc_slots #(
    .ENTRIES (ENTRIES)
  ) u_slots (
    .clk      (clk),
    .rst_n    (rst_n),
    .capacity (capacity_r),
    .upd_en   (proc && !stage_is_get),
    .req      (stage_r),
    .lookup   (lookup)
  );

  // result register
  always_ff @(posedge clk) begin
    if (proc && stage_is_get) begin
      out_r <= lookup;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_r.hit;
  assign out_read_value = out_r.value;

endmodule

### sim/lkvc_lookup_checker.sv
// ----------------------------------------------------------------------------
// lkvc_lookup_checker: result checker for the lru key/value cache
// watches request, result and capacity beats, keeps its own copy of the
// store and ranks, and compares every result beat with the predicted lookup
// ----------------------------------------------------------------------------
module lkvc_lookup_checker
  import lkvc_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_req_type,
  input  logic signed [31:0] in_lookup_key,
  input  logic signed [31:0] in_write_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_hit,
  input  logic signed [31:0] out_read_value,
  input  logic               cfg_wr_en,
  input  logic [4:0]         cfg_wr_data,
  output int unsigned        error_count,
  output int unsigned        pending_lookups,
  output int unsigned        checked_lookups,
  output int unsigned        hit_lookups
);

  logic [4:0]         capacity_q;
  logic               line_live [ENTRIES];
  logic signed [31:0] line_key  [ENTRIES];
  logic signed [31:0] line_data [ENTRIES];
  int unsigned        line_rank [ENTRIES];
  lookup_t            expected_lookups [$];

  initial begin
    error_count     = 0;
    pending_lookups = 0;
    checked_lookups = 0;
    hit_lookups     = 0;
  end

  // zero acts as one, large values saturate at the slot count
  function automatic int unsigned kept_lines();
    int unsigned n;
    n = capacity_q;
    if (n == 0) begin
      n = 1;
    end else if (n > ENTRIES) begin
      n = ENTRIES;
    end
    return n;
  endfunction

  function automatic int lookup_line(logic signed [31:0] key);
    int found;
    found = -1;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (line_live[i] && line_key[i] == key) found = i;
    end
    return found;
  endfunction

  function automatic void store_entry(logic signed [31:0] key, logic signed [31:0] data);
    int          idx;
    int          spare;
    int unsigned old_rank;
    int unsigned keep;
    idx = lookup_line(key);
    if (idx >= 0) begin
      // update: younger lines age by one, this line becomes newest
      old_rank = line_rank[idx];
      for (int i = 0; i < ENTRIES; i++) begin
        if (line_live[i] && line_rank[i] < old_rank) line_rank[i]++;
      end
      line_rank[idx] = 0;
      line_data[idx] = data;
    end else begin
      // insert: drop everything at or past the last kept rank, then age the survivors
      keep  = kept_lines() - 1;
      spare = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (line_live[i] && line_rank[i] >= keep) begin
          line_live[i] = 1'b0;
          line_rank[i] = 0;
        end
      end
      for (int i = 0; i < ENTRIES; i++) begin
        if (line_live[i]) begin
          line_rank[i]++;
        end else if (spare < 0) begin
          spare = i;
        end
      end
      if (spare >= 0) begin
        line_live[spare] = 1'b1;
        line_key[spare]  = key;
        line_data[spare] = data;
        line_rank[spare] = 0;
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    lookup_t want;
    int      idx;
    if (!rst_n) begin
      capacity_q = CAPACITY_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
        line_live[i] = 1'b0;
        line_rank[i] = 0;
      end
      expected_lookups.delete();
      pending_lookups = 0;
    end else begin
      // results first: a beat leaving now belongs to an earlier get
      if (out_valid && !out_stall) begin
        if (expected_lookups.size() == 0) begin
          $error("unexpected result beat: hit %0b, read_value %0d", out_hit, out_read_value);
          error_count++;
        end else begin
          want = expected_lookups.pop_front();
          checked_lookups++;
          if (want.hit) hit_lookups++;
          if (out_hit !== want.hit) begin
            $error("hit: expected %0b, actual %0b", want.hit, out_hit);
            error_count++;
          end
          if (out_read_value !== want.value) begin
            $error("read_value: expected %0d, actual %0d", want.value, out_read_value);
            error_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (req_kind_t'(in_req_type) == REQ_SET) begin
          store_entry(in_lookup_key, in_write_value);
        end else begin
          idx = lookup_line(in_lookup_key);
          if (idx >= 0) begin
            want.hit   = 1'b1;
            want.value = line_data[idx];
          end else begin
            want.hit   = 1'b0;
            want.value = MISS_VALUE;
          end
          expected_lookups.push_back(want);
        end
      end
      if (cfg_wr_en) capacity_q = cfg_wr_data;
      pending_lookups = expected_lookups.size();
    end
  end

endmodule

### sim/lru_key_value_cache_tb.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb: testbench for the lru key/value cache
// directed gets and sets around eviction, updates and capacity corners, then
// random phases over a small key pool per capacity setting, with random
// request gaps and result stalls; a separate checker predicts every lookup
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;
  import lkvc_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 4;       // margin after the last lookup returns
  localparam int POOL_MAX      = 32;
  localparam int PHASE_BEATS   = 66;

  localparam logic signed [31:0] WORD_MIN  = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX  = 32'sh7fff_ffff;
  localparam logic signed [31:0] WORD_ONES = -32'sd1;

  // every block input starts at a known value
  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic               in_req_type    = REQ_GET;
  logic signed [31:0] in_lookup_key  = '0;
  logic signed [31:0] in_write_value = '0;
  logic               out_valid;
  logic               out_stall      = 1'b0;
  logic               out_hit;
  logic signed [31:0] out_read_value;
  logic               cfg_wr_en      = 1'b0;
  logic [4:0]         cfg_wr_data    = '0;

  int unsigned fail_count;
  int unsigned pending_lookups;
  int unsigned checked_lookups;
  int unsigned hit_lookups;

  int unsigned cycle_count   = 0;
  int unsigned get_count     = 0;
  int unsigned set_count     = 0;
  int unsigned setting_count = 0;

  // when set, neither side idles: back-to-back beats for the closing phase
  bit calm = 1'b0;

  // keys for one random phase; a small pool keeps hits and evictions common
  logic signed [31:0] key_pool [POOL_MAX];
  int                 pool_size = 1;

  always #1 clk = ~clk;

  lru_key_value_cache #(
    .ENTRIES(16)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_lookup_key (in_lookup_key),
    .in_write_value(in_write_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hit       (out_hit),
    .out_read_value(out_read_value),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  lkvc_lookup_checker #(
    .ENTRIES(16)
  ) lookup_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_lookup_key  (in_lookup_key),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .error_count    (fail_count),
    .pending_lookups(pending_lookups),
    .checked_lookups(checked_lookups),
    .hit_lookups    (hit_lookups)
  );

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lru_key_value_cache_tb: done, errors");
      $finish;
    end
  end

  // result-side backpressure: random stall bursts mixed with free runs
  int stall_left = 0;
  int free_left  = 0;
  always @(negedge clk) begin
    if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (free_left > 0) begin
      out_stall <= 1'b0;
      free_left--;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 18);
      else free_left = $urandom_range(1, 24);
    end
  end

  // one request beat; held until taken, with an occasional gap in front
  task automatic send_request(req_kind_t kind, logic signed [31:0] key,
                              logic signed [31:0] data);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_req_type    <= kind;
    in_lookup_key  <= key;
    in_write_value <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (kind == REQ_GET) get_count++;
    else set_count++;
  endtask

  // drop valid, wait for every lookup to come back, then let a trailing set
  // finish inside the block
  task automatic drain_requests();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_lookups != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // capacity writes only land while the block is idle
  task automatic write_capacity(logic [4:0] cap);
    drain_requests();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    setting_count++;
  endtask

  // mostly random keys, with the signed extremes thrown in now and then
  task automatic fill_pool(int n);
    pool_size = n;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0:       key_pool[i] = WORD_MIN;
        1:       key_pool[i] = WORD_MAX;
        default: key_pool[i] = $urandom;
      endcase
    end
  endtask

  function automatic req_kind_t pick_kind();
    return ($urandom_range(0, 99) < 55) ? REQ_SET : REQ_GET;
  endfunction

  // pool keys most of the time, a fresh key as noise
  function automatic logic signed [31:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, pool_size - 1)];
    return $urandom;
  endfunction

  function automatic logic signed [31:0] pick_data();
    case ($urandom_range(0, 11))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return WORD_ONES;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_phase(logic [4:0] cap, int pool_n);
    write_capacity(cap);
    fill_pool(pool_n);
    repeat (PHASE_BEATS) send_request(pick_kind(), pick_key(), pick_data());
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // reset capacity of five: lookup on an empty store, then fill it
    send_request(REQ_GET, WORD_MIN, 32'sd0);
    send_request(REQ_SET, WORD_MIN, WORD_MAX);
    send_request(REQ_SET, WORD_MAX, WORD_MIN);
    send_request(REQ_SET, 32'sd0, 32'sd0);
    send_request(REQ_SET, WORD_ONES, WORD_ONES);  // hit that reads like a miss
    send_request(REQ_SET, 32'sd5, 32'sd123);
    send_request(REQ_GET, WORD_MIN, 32'sd0);      // get leaves recency alone
    send_request(REQ_SET, WORD_MIN, 32'sd77);     // update makes it newest
    send_request(REQ_SET, 32'sd99, 32'sd1);       // full store: oldest goes
    send_request(REQ_GET, WORD_MAX, 32'sd0);
    send_request(REQ_GET, WORD_MIN, 32'sd0);
    send_request(REQ_GET, WORD_ONES, 32'sd0);

    // capacity lowered under occupancy: nothing leaves until an insertion
    write_capacity(5'd2);
    send_request(REQ_GET, 32'sd0, 32'sd0);
    send_request(REQ_SET, 32'sd5, 32'sd6);        // update evicts nothing
    send_request(REQ_SET, 32'sd1000, 32'sd7);     // insert trims to one old line
    send_request(REQ_GET, WORD_MIN, 32'sd0);
    send_request(REQ_GET, 32'sd5, 32'sd0);
    send_request(REQ_GET, 32'sd1000, 32'sd0);

    // capacity zero behaves as one
    write_capacity(5'd0);
    send_request(REQ_SET, 32'sd42, 32'sd1);
    send_request(REQ_GET, 32'sd1000, 32'sd0);
    send_request(REQ_GET, 32'sd42, 32'sd0);

    // random phases; the top setting saturates at the slot count
    run_phase(5'd31, 22);
    run_phase(5'd16, 20);
    run_phase(5'd1, 3);
    run_phase(5'd17, 24);
    run_phase(5'd3, 6);
    run_phase(5'd0, 4);
    run_phase(5'd8, 12);
    run_phase(5'd12, 16);

    // closing phase without any idling on either side
    @(posedge clk);
    calm = 1'b1;
    run_phase(5'd5, 8);

    drain_requests();
    $display("covered %0d requests (%0d gets, %0d sets) across %0d capacity writes",
             get_count + set_count, get_count, set_count, setting_count);
    $display("checked %0d lookup results, %0d of them hits", checked_lookups, hit_lookups);
    if (fail_count == 0) begin
      $display("lru_key_value_cache_tb: done, clean");
    end else begin
      $display("lru_key_value_cache_tb: done, errors");
    end
    $finish;
  end

endmodule
